// File: sv/scs_pkg.sv
`default_nettype none
package scs_pkg;

    localparam int CORDIC_STAGES_DEF = 24;
    localparam int CORDIC_STAGES_MAX = 31;

    // angle path width: Q4.28 plus headroom for one 2*pi fold
    localparam int ANG_W = 34;
    // cos/sin width, Q2.30 plus headroom
    localparam int CS_W  = 34;

    localparam logic signed [ANG_W-1:0] ANG_PI      = 34'sd843314857;
    localparam logic signed [ANG_W-1:0] ANG_TWO_PI  = 34'sd1686629713;
    localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 34'sd421657428;
    localparam logic signed [CS_W-1:0]  CORDIC_K    = 34'sd652032874;

    typedef struct packed {
        logic signed [31:0] radius_value;
        logic               radius_present;
        logic signed [31:0] plane_angle;
        logic               plane_angle_present;
        logic signed [31:0] elevation_angle;
        logic               elevation_present;
    } scs_in_t;

    typedef struct packed {
        logic signed [31:0] x_coord;
        logic               x_valid;
        logic signed [31:0] y_coord;
        logic               y_valid;
        logic signed [31:0] z_coord;
        logic               z_valid;
    } scs_out_t;

    // radius and presence flags riding alongside the angle pipes
    typedef struct packed {
        logic signed [31:0] radius;
        logic               rp;
        logic               pp;
        logic               ep;
    } scs_side_t;

    // atan(2^-i) in Q4.28, rounded
    function automatic logic signed [ANG_W-1:0] atan_q28(input int idx);
        logic signed [ANG_W-1:0] v;
        case (idx)
            0:  v = 34'sd210828714;
            1:  v = 34'sd124459457;
            2:  v = 34'sd65760959;
            3:  v = 34'sd33381290;
            4:  v = 34'sd16755422;
            5:  v = 34'sd8385879;
            6:  v = 34'sd4193963;
            7:  v = 34'sd2097109;
            8:  v = 34'sd1048571;
            9:  v = 34'sd524287;
            10: v = 34'sd262144;
            11: v = 34'sd131072;
            12: v = 34'sd65536;
            13: v = 34'sd32768;
            14: v = 34'sd16384;
            15: v = 34'sd8192;
            16: v = 34'sd4096;
            17: v = 34'sd2048;
            18: v = 34'sd1024;
            19: v = 34'sd512;
            20: v = 34'sd256;
            21: v = 34'sd128;
            22: v = 34'sd64;
            23: v = 34'sd32;
            24: v = 34'sd16;
            25: v = 34'sd8;
            26: v = 34'sd4;
            27: v = 34'sd2;
            28: v = 34'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Q16.16 x Q2.30 product back to Q16.16, round half up, clamp to 32 bits
    function automatic logic signed [31:0] round_sat(input logic signed [67:0] p);
        logic signed [67:0] t;
        t = (p + 68'sd536870912) >>> 30;
        if (t > 68'sd2147483647)
            return 32'sh7fffffff;
        else if (t < -68'sd2147483648)
            return 32'sh80000000;
        else
            return t[31:0];
    endfunction

endpackage
`default_nettype wire

// File: sv/scs_range.sv
`default_nettype none
module scs_range (
    input  wire                              aclk,
    input  wire                              en,
    input  wire logic signed [31:0]          angle,
    output logic signed [scs_pkg::ANG_W-1:0] red_angle,
    output logic                             neg
);
    import scs_pkg::*;

    logic signed [ANG_W-1:0] a_in;
    logic signed [ANG_W-1:0] fold_reg, fold_next;
    logic signed [ANG_W-1:0] half_reg, half_next;
    logic                    neg_reg, neg_next;

    assign a_in = ANG_W'(angle);

    // bring into [-pi, pi]
    always_comb begin
        if (a_in > ANG_PI)
            fold_next = a_in - ANG_TWO_PI;
        else if (a_in < -ANG_PI)
            fold_next = a_in + ANG_TWO_PI;
        else
            fold_next = a_in;
    end

    // bring into [-pi/2, pi/2], remember the sign flip
    always_comb begin
        neg_next  = 1'b0;
        half_next = fold_reg;
        if (fold_reg > ANG_HALF_PI) begin
            half_next = fold_reg - ANG_PI;
            neg_next  = 1'b1;
        end else if (fold_reg < -ANG_HALF_PI) begin
            half_next = fold_reg + ANG_PI;
            neg_next  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fold_reg <= fold_next;
            half_reg <= half_next;
            neg_reg  <= neg_next;
        end
    end

    assign red_angle = half_reg;
    assign neg       = neg_reg;
endmodule
`default_nettype wire

// File: sv/scs_cordic.sv
`default_nettype none
module scs_cordic #(
    parameter int STAGES = scs_pkg::CORDIC_STAGES_DEF
) (
    input  wire                              aclk,
    input  wire                              en,
    input  wire logic signed [scs_pkg::ANG_W-1:0] angle,
    input  wire                              neg,
    output logic signed [scs_pkg::CS_W-1:0]  cos_out,
    output logic signed [scs_pkg::CS_W-1:0]  sin_out
);
    import scs_pkg::*;

    logic signed [CS_W-1:0]  x_reg [0:STAGES];
    logic signed [CS_W-1:0]  y_reg [0:STAGES];
    logic signed [ANG_W-1:0] z_reg [0:STAGES];
    logic                    neg_reg [0:STAGES];
    logic signed [CS_W-1:0]  cos_reg, sin_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]   <= CORDIC_K;
            y_reg[0]   <= '0;
            z_reg[0]   <= angle;
            neg_reg[0] <= neg;
        end
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        logic signed [CS_W-1:0]  x_next, y_next;
        logic signed [ANG_W-1:0] z_next;

        always_comb begin
            if (!z_reg[i][ANG_W-1]) begin
                x_next = x_reg[i] - (y_reg[i] >>> i);
                y_next = y_reg[i] + (x_reg[i] >>> i);
                z_next = z_reg[i] - atan_q28(i);
            end else begin
                x_next = x_reg[i] + (y_reg[i] >>> i);
                y_next = y_reg[i] - (x_reg[i] >>> i);
                z_next = z_reg[i] + atan_q28(i);
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[i+1]   <= x_next;
                y_reg[i+1]   <= y_next;
                z_reg[i+1]   <= z_next;
                neg_reg[i+1] <= neg_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cos_reg <= neg_reg[STAGES] ? -x_reg[STAGES] : x_reg[STAGES];
            sin_reg <= neg_reg[STAGES] ? -y_reg[STAGES] : y_reg[STAGES];
        end
    end

    assign cos_out = cos_reg;
    assign sin_out = sin_reg;
endmodule
`default_nettype wire

// File: sv/scs_product.sv
`default_nettype none
module scs_product (
    input  wire                              aclk,
    input  wire                              en,
    input  wire scs_pkg::scs_side_t          side,
    input  wire logic signed [scs_pkg::CS_W-1:0] cp,
    input  wire logic signed [scs_pkg::CS_W-1:0] sp,
    input  wire logic signed [scs_pkg::CS_W-1:0] ce,
    input  wire logic signed [scs_pkg::CS_W-1:0] se,
    output scs_pkg::scs_out_t                result
);
    import scs_pkg::*;

    // stage 1: r*cos(elev), r*sin(elev)
    scs_side_t               s1_side_reg;
    logic signed [CS_W-1:0]  s1_cp_reg, s1_sp_reg;
    logic signed [65:0]      s1_prc_reg, s1_pz_reg;
    // stage 2: rounded multiplicand, finished z
    scs_side_t               s2_side_reg;
    logic signed [CS_W-1:0]  s2_cp_reg, s2_sp_reg;
    logic signed [33:0]      s2_mop_reg, s2_mop_next;
    logic signed [31:0]      s2_z_reg;
    logic signed [35:0]      rc_full;
    // stage 3: x and y products
    scs_side_t               s3_side_reg;
    logic signed [31:0]      s3_z_reg;
    logic signed [67:0]      s3_px_reg, s3_py_reg;
    // stage 4: result
    scs_out_t                res_reg, res_next;

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_side_reg <= side;
            s1_cp_reg   <= cp;
            s1_sp_reg   <= sp;
            s1_prc_reg  <= 66'(side.radius) * 66'(ce);
            s1_pz_reg   <= 66'(side.radius) * 66'(se);
        end
    end

    assign rc_full = 36'((68'(s1_prc_reg) + 68'sd536870912) >>> 30);

    // rc is kept unsaturated; 2-D form multiplies the radius directly
    always_comb begin
        if (s1_side_reg.ep)
            s2_mop_next = rc_full[33:0];
        else
            s2_mop_next = 34'(s1_side_reg.radius);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_side_reg <= s1_side_reg;
            s2_cp_reg   <= s1_cp_reg;
            s2_sp_reg   <= s1_sp_reg;
            s2_mop_reg  <= s2_mop_next;
            s2_z_reg    <= round_sat(68'(s1_pz_reg));
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s3_side_reg <= s2_side_reg;
            s3_z_reg    <= s2_z_reg;
            s3_px_reg   <= 68'(s2_mop_reg) * 68'(s2_cp_reg);
            s3_py_reg   <= 68'(s2_mop_reg) * 68'(s2_sp_reg);
        end
    end

    always_comb begin
        res_next = '0;
        if (s3_side_reg.rp) begin
            if (!s3_side_reg.pp) begin
                res_next.x_coord = s3_side_reg.radius;
                res_next.x_valid = 1'b1;
            end else begin
                res_next.x_coord = round_sat(s3_px_reg);
                res_next.x_valid = 1'b1;
                res_next.y_coord = round_sat(s3_py_reg);
                res_next.y_valid = 1'b1;
                if (s3_side_reg.ep) begin
                    res_next.z_coord = s3_z_reg;
                    res_next.z_valid = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en)
            res_reg <= res_next;
    end

    assign result = res_reg;
endmodule
`default_nettype wire

// File: sv/spherical_to_cartesian.sv
`default_nettype none
// Spherical to cartesian converter. Radius and results are signed Q16.16,
// angles signed Q4.28 radians; each coordinate carries its own valid flag
// and saturates to 32 bits. Fully pipelined: one request per cycle unless the
// output stalls. Data passes the angle fold, the two parallel CORDIC pipes and
// the multiply/round/saturate stages, output register included. Back-pressure
// on m_ready freezes the whole pipe, so s_ready follows m_ready whenever a
// result is waiting.
module spherical_to_cartesian #(
    parameter int CORDIC_STAGES = scs_pkg::CORDIC_STAGES_DEF
) (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 s_valid,
    output logic                s_ready,
    input  wire scs_pkg::scs_in_t s_data,
    output logic                m_valid,
    input  wire                 m_ready,
    output scs_pkg::scs_out_t   m_data
);
    import scs_pkg::*;

    localparam int NST      = (CORDIC_STAGES > CORDIC_STAGES_MAX) ?
                              CORDIC_STAGES_MAX : CORDIC_STAGES;
    localparam int SIDE_LAT = NST + 4;
    localparam int LAT      = NST + 8;

    logic                    en;
    logic                    vld_reg [0:LAT-1];
    scs_side_t               side_reg [0:SIDE_LAT-1];
    scs_side_t               side_in;
    logic signed [ANG_W-1:0] pa_red, ea_red;
    logic                    pa_neg, ea_neg;
    logic signed [CS_W-1:0]  cp, sp, ce, se;

    assign en      = m_ready || !m_valid;
    assign s_ready = en;
    assign m_valid = vld_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < LAT; k++)
                vld_reg[k] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= s_valid;
            for (int k = 1; k < LAT; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    assign side_in.radius = s_data.radius_value;
    assign side_in.rp     = s_data.radius_present;
    assign side_in.pp     = s_data.plane_angle_present;
    assign side_in.ep     = s_data.elevation_present;

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= side_in;
            for (int k = 1; k < SIDE_LAT; k++)
                side_reg[k] <= side_reg[k-1];
        end
    end

    scs_range u_range_pa (
        .aclk      (aclk),
        .en        (en),
        .angle     (s_data.plane_angle),
        .red_angle (pa_red),
        .neg       (pa_neg)
    );

    scs_range u_range_ea (
        .aclk      (aclk),
        .en        (en),
        .angle     (s_data.elevation_angle),
        .red_angle (ea_red),
        .neg       (ea_neg)
    );

    scs_cordic #(.STAGES(NST)) u_cordic_pa (
        .aclk    (aclk),
        .en      (en),
        .angle   (pa_red),
        .neg     (pa_neg),
        .cos_out (cp),
        .sin_out (sp)
    );

    scs_cordic #(.STAGES(NST)) u_cordic_ea (
        .aclk    (aclk),
        .en      (en),
        .angle   (ea_red),
        .neg     (ea_neg),
        .cos_out (ce),
        .sin_out (se)
    );

    scs_product u_product (
        .aclk   (aclk),
        .en     (en),
        .side   (side_reg[SIDE_LAT-1]),
        .cp     (cp),
        .sp     (sp),
        .ce     (ce),
        .se     (se),
        .result (m_data)
    );
endmodule
`default_nettype wire

// File: sv/scs_checker.sv
`default_nettype none
module scs_checker (
    input wire                    aclk,
    input wire                    aresetn,
    input wire                    s_ready,
    input wire                    m_valid,
    input wire                    m_ready,
    input wire scs_pkg::scs_out_t m_data
);
    // a held result must not change
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // pipe only stalls on a waiting result
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid || m_ready |-> s_ready)
        else $error("input blocked with free output");

    a_yx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.y_valid |-> m_data.x_valid)
        else $error("y valid without x");

    a_zy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.z_valid |-> m_data.y_valid)
        else $error("z valid without y");

    a_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.x_valid |-> m_data.x_coord == 32'sd0 &&
            m_data.y_coord == 32'sd0 && m_data.z_coord == 32'sd0)
        else $error("absent radius gave nonzero coordinate");
endmodule

bind spherical_to_cartesian scs_checker u_scs_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
`default_nettype wire
